// ===== sv/dqr_pkg.sv =====
// dqr_pkg: shared types and codes for the double-ended queue with remove
// used by dqr_cell, double_ended_queue_with_remove and dqr_checker
package dqr_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CNT_OUT_W = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SH_UP = 2'd1,
    CELL_SH_DN = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic                      load_en;
    logic signed [DATA_W-1:0]  load_data;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  first_value;
    logic signed [DATA_W-1:0]  last_value;
    logic [CNT_OUT_W-1:0]      entry_count;
    logic                      is_empty;
    logic [1:0]                status;
  } out_t;

endpackage

// ===== sv/dqr_cell.sv =====
// dqr_cell: one storage cell of the queue chain
// takes its left or right neighbor, a broadcast load, or holds; uses dqr_pkg
module dqr_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  dqr_pkg::cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]                  load_idx,
  input  logic signed [dqr_pkg::DATA_W-1:0] left_data,
  input  logic signed [dqr_pkg::DATA_W-1:0] right_data,
  output logic signed [dqr_pkg::DATA_W-1:0] data
);

  logic signed [dqr_pkg::DATA_W-1:0] data_r;
  logic signed [dqr_pkg::DATA_W-1:0] data_nxt;
  logic                              hit;

  assign hit = ctrl.load_en && (load_idx == IDX_W'(IDX));

  always_comb begin
    data_nxt = data_r;
    if (hit) begin
      data_nxt = ctrl.load_data;
    end else begin
      unique case (ctrl.op)
        dqr_pkg::CELL_SH_UP: data_nxt = left_data;
        dqr_pkg::CELL_SH_DN: data_nxt = right_data;
        default:             data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== sv/double_ended_queue_with_remove.sv =====
// double_ended_queue_with_remove: top level, command sequencer over a chain of dqr_cell
// depends on dqr_pkg and dqr_cell
//
//   channel | ports                           | beat
//   --------+---------------------------------+------------------------------------
//   input   | in_valid, in_stall, in_data     | one command (cmd, value)
//   output  | out_valid, out_stall, out_data  | one result (first, last, count, flags)
//
// push front, push back, pop front, clear and no-op commands, and pop back or remove on an empty queue,
// go from idle straight to the result state; pop back and remove otherwise rotate the occupied entries
// once in the rotate state, one cell shift per cycle
// one command is in flight at a time; in_stall is high from accept until the result is registered
// a stalled result holds in the output register; the next command may be taken meanwhile
// synchronous active-low reset empties the queue; cell contents are not reset
module double_ended_queue_with_remove #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dqr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dqr_pkg::out_t out_data
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROT  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [CntW-1:0]                    occ_r, occ_nxt;
  logic [CntW-1:0]                    rot_r, rot_nxt;
  logic [CntW-1:0]                    occ_m1;
  logic signed [dqr_pkg::DATA_W-1:0]  last_r, last_nxt;
  logic signed [dqr_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [dqr_pkg::CMD_W-1:0]          cmd_r, cmd_nxt;
  dqr_pkg::status_t                   stat_r, stat_nxt;
  logic                               out_vld_r, out_vld_nxt;
  dqr_pkg::out_t                      out_data_r, out_data_nxt;
  dqr_pkg::cell_ctrl_t                ctrl;
  logic [IdxW-1:0]                    load_idx;
  logic signed [dqr_pkg::DATA_W-1:0]  cell_q [DEPTH];
  logic signed [dqr_pkg::DATA_W-1:0]  head;
  logic                               full, empty, drop;
  logic [CntW+dqr_pkg::CNT_OUT_W-1:0] cnt_wide;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dqr_pkg::DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_lo
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign right_d = cell_q[i];
    end else begin : g_hi
      assign right_d = cell_q[i+1];
    end
    dqr_cell #(
      .IDX_W (IdxW),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_idx   (load_idx),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

  assign head     = cell_q[0];
  assign full     = (occ_r == CntW'(DEPTH));
  assign empty    = (occ_r == '0);
  assign occ_m1   = occ_r - CntW'(1);
  assign drop     = ((cmd_r == dqr_pkg::CMD_REMOVE) && (head == val_r)) ||
                    ((cmd_r == dqr_pkg::CMD_POP_BACK) && (rot_r == CntW'(1)));
  assign cnt_wide = {{dqr_pkg::CNT_OUT_W{1'b0}}, occ_r};

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    rot_nxt        = rot_r;
    last_nxt       = last_r;
    val_nxt        = val_r;
    cmd_nxt        = cmd_r;
    stat_nxt       = stat_r;
    out_vld_nxt    = out_vld_r;
    out_data_nxt   = out_data_r;
    ctrl.op        = dqr_pkg::CELL_HOLD;
    ctrl.load_en   = 1'b0;
    ctrl.load_data = in_data.value;
    load_idx       = '0;

    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          val_nxt   = in_data.value;
          stat_nxt  = dqr_pkg::ST_OK;
          state_nxt = S_RES;
          unique case (in_data.cmd)
            dqr_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                stat_nxt = dqr_pkg::ST_FULL;
              end else begin
                ctrl.op      = dqr_pkg::CELL_SH_UP;
                ctrl.load_en = 1'b1;
                occ_nxt      = occ_r + CntW'(1);
                if (empty) begin
                  last_nxt = in_data.value;
                end
              end
            end
            dqr_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                stat_nxt = dqr_pkg::ST_FULL;
              end else begin
                ctrl.load_en = 1'b1;
                load_idx     = occ_r[IdxW-1:0];
                occ_nxt      = occ_r + CntW'(1);
                last_nxt     = in_data.value;
              end
            end
            dqr_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                stat_nxt = dqr_pkg::ST_EMPTY;
              end else begin
                ctrl.op = dqr_pkg::CELL_SH_DN;
                occ_nxt = occ_m1;
              end
            end
            dqr_pkg::CMD_POP_BACK: begin
              if (empty) begin
                stat_nxt = dqr_pkg::ST_EMPTY;
              end else begin
                rot_nxt   = occ_r;
                state_nxt = S_ROT;
              end
            end
            dqr_pkg::CMD_REMOVE: begin
              if (!empty) begin
                rot_nxt   = occ_r;
                state_nxt = S_ROT;
              end
            end
            dqr_pkg::CMD_CLEAR: begin
              occ_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROT: begin
        ctrl.op        = dqr_pkg::CELL_SH_DN;
        ctrl.load_en   = !drop;
        ctrl.load_data = head;
        load_idx       = occ_m1[IdxW-1:0];
        if (drop) begin
          occ_nxt = occ_m1;
        end else begin
          last_nxt = head;
        end
        rot_nxt = rot_r - CntW'(1);
        if (rot_r == CntW'(1)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt              = 1'b1;
          out_data_nxt.first_value = empty ? '0 : head;
          out_data_nxt.last_value  = empty ? '0 : last_r;
          out_data_nxt.entry_count = cnt_wide[dqr_pkg::CNT_OUT_W-1:0];
          out_data_nxt.is_empty    = empty;
          out_data_nxt.status      = stat_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_r      <= rot_nxt;
    last_r     <= last_nxt;
    val_r      <= val_nxt;
    cmd_r      <= cmd_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/dqr_checker.sv =====
// dqr_checker: port-level checks for double_ended_queue_with_remove, bound to the top level
// depends on dqr_pkg
module dqr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input dqr_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one command in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  // empty queue reports zero values and count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.entry_count == '0 && out_data.first_value == '0 &&
      out_data.last_value == '0)
    else $error("empty result with nonzero fields");

  // pop on empty leaves the queue empty
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == dqr_pkg::ST_EMPTY |-> out_data.is_empty)
    else $error("pop on empty reported a nonempty queue");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind double_ended_queue_with_remove dqr_checker u_dqr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/double_ended_queue_with_remove_test.sv =====
// double_ended_queue_with_remove_test: self-checking bench for the double-ended queue with remove
// runs directed end cases and random command traffic against a queue-based prediction
// depends on dqr_pkg and double_ended_queue_with_remove
module double_ended_queue_with_remove_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqr_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam int RANDOM_PER_PHASE = 255;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic signed [DATA_W-1:0] held_values[$];
  out_t expected_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit filling = 1'b1;

  double_ended_queue_with_remove #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // queue-level prediction of one command
  task automatic apply_command(input in_t beat, output out_t res);
    logic signed [DATA_W-1:0] kept[$];
    status_t st;
    st = ST_OK;
    case (beat.cmd)
      CMD_PUSH_FRONT: begin
        if (held_values.size() >= QUEUE_DEPTH) st = ST_FULL;
        else held_values.push_front(beat.value);
      end
      CMD_PUSH_BACK: begin
        if (held_values.size() >= QUEUE_DEPTH) st = ST_FULL;
        else held_values.push_back(beat.value);
      end
      CMD_POP_FRONT: begin
        if (held_values.size() == 0) st = ST_EMPTY;
        else void'(held_values.pop_front());
      end
      CMD_POP_BACK: begin
        if (held_values.size() == 0) st = ST_EMPTY;
        else void'(held_values.pop_back());
      end
      CMD_REMOVE: begin
        foreach (held_values[i]) begin
          if (held_values[i] != beat.value) kept.push_back(held_values[i]);
        end
        held_values = kept;
      end
      CMD_CLEAR: begin
        held_values.delete();
      end
      default: begin
      end
    endcase
    if (held_values.size() == 0) begin
      res.first_value = '0;
      res.last_value = '0;
      res.is_empty = 1'b1;
    end else begin
      res.first_value = held_values[0];
      res.last_value = held_values[held_values.size() - 1];
      res.is_empty = 1'b0;
    end
    res.entry_count = CNT_OUT_W'(held_values.size());
    res.status = st;
  endtask

  task automatic pause_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value);
    in_t beat;
    out_t res;
    beat.cmd = cmd;
    beat.value = value;
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_command(beat, res);
    expected_results.push_back(res);
    pause_sender();
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_data.first_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.first_value !== want.first_value)
          report_mismatch("first_value", out_data.first_value, want.first_value);
        if (out_data.last_value !== want.last_value)
          report_mismatch("last_value", out_data.last_value, want.last_value);
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", DATA_W'(out_data.entry_count),
                          DATA_W'(want.entry_count));
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(out_data.is_empty), DATA_W'(want.is_empty));
        if (out_data.status !== want.status)
          report_mismatch("status", DATA_W'(out_data.status), DATA_W'(want.status));
      end
    end
  end

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int small_val;
    case ($urandom_range(3))
      0: begin
        small_val = $urandom_range(0, 7);
        return small_val - 4;
      end
      1: return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_store();
    send_command(CMD_POP_FRONT, 32'sd7);
    send_command(CMD_POP_BACK, -32'sd7);
    send_command(CMD_CLEAR, '0);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_SPARE_LO, VALUE_MAX);
    send_command(CMD_SPARE_HI, VALUE_MIN);
  endtask

  task automatic test_extreme_values();
    send_command(CMD_PUSH_BACK, VALUE_MAX);
    send_command(CMD_PUSH_FRONT, VALUE_MIN);
    send_command(CMD_REMOVE, 32'sd1);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
  endtask

  // fill to capacity with one value, overflow both ends, then remove all at once
  task automatic test_full_store();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_command(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, -32'sd1);
    end
    send_command(CMD_PUSH_BACK, 32'sd3);
    send_command(CMD_PUSH_FRONT, 32'sd4);
    send_command(CMD_REMOVE, -32'sd1);
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    int push_share;
    int pop_share;
    logic [CMD_W-1:0] cmd;
    logic signed [DATA_W-1:0] value;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 31) filling = !filling;
      push_share = filling ? 55 : 20;
      pop_share = filling ? 20 : 50;
      r = $urandom_range(99);
      value = pick_value();
      if (r < push_share) begin
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else if (r < push_share + pop_share) begin
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end else if (r < 96) begin
        cmd = CMD_REMOVE;
        if (held_values.size() != 0 && $urandom_range(99) < 75)
          value = held_values[$urandom_range(held_values.size() - 1)];
      end else if (r < 98) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end
      send_command(cmd, value);
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_empty_store();
    test_extreme_values();
    test_full_store();
    test_random_traffic(RANDOM_PER_PHASE);
    set_idling(79, 0);
    test_random_traffic(RANDOM_PER_PHASE);
    set_idling(0, 79);
    test_random_traffic(RANDOM_PER_PHASE);
    set_idling(23, 23);
    test_random_traffic(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), '0);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
